// ----- rtl/smtp_seq_pkg.sv -----
// smtp_seq_pkg: types, codes and the control store of the smtp/lmtp client command sequencer
// no dependencies; used by smtp_client_command_sequencer_top
`timescale 1ns / 1ps

package smtp_seq_pkg;

    // recipients per envelope, larger counts are clamped
    localparam int unsigned RCPT_MAX = 32;

    typedef enum logic [3:0] {
        ST_START         = 4'd0,
        ST_START_XCLIENT = 4'd1,
        ST_HELLO         = 4'd2,
        ST_HELLO_XCLIENT = 4'd3,
        ST_AFTER_MAIL    = 4'd4,
        ST_AFTER_RCPT    = 4'd5,
        ST_AFTER_DATA    = 4'd6,
        ST_AFTER_DOT     = 4'd7,
        ST_AFTER_QUIT    = 4'd8,
        ST_ERROR         = 4'd9
    } proto_state_t;

    typedef enum logic [3:0] {
        A_EHLO    = 4'd0,
        A_LHLO    = 4'd1,
        A_XCLIENT = 4'd2,
        A_MAIL    = 4'd3,
        A_RCPT    = 4'd4,
        A_DATA    = 4'd5,
        A_BODY    = 4'd6,
        A_STATUS  = 4'd7,
        A_QUIT    = 4'd8,
        A_CLOSE   = 4'd9,
        A_FAULT   = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        OP_CONNECT = 2'd0,
        OP_REPLY   = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // fault kinds; unexpected replies use FK_STATE_BASE plus the state code
    localparam logic [3:0] FK_NONE       = 4'd0;
    localparam logic [3:0] FK_BAD_CODE   = 4'd1;
    localparam logic [3:0] FK_STATE_BASE = 4'd2;
    localparam logic [3:0] FK_NO_RCPT    = 4'd9;
    localparam logic [3:0] FK_TIMEOUT    = 4'd10;

    localparam logic [9:0] CODE_GREETING = 10'd220;
    localparam logic [9:0] CODE_OK       = 10'd250;
    localparam logic [9:0] CODE_DATA_GO  = 10'd354;

    // register indexes of the configuration port
    localparam logic CFG_LMTP_MODE  = 1'b0;
    localparam logic CFG_RCPT_COUNT = 1'b1;

    // one control word per step
    typedef struct packed {
        action_t act;
        logic    hello;     // action is EHLO or LHLO by mode
        logic    loop;      // repeat over recipients 0 .. total-1
        logic    use_idx;   // recipient index from the decoded argument
        logic    use_code;  // status code from the reply
        logic    use_kind;  // fault kind from the decoded argument
        logic    succ;
        logic    last_step;
    } ucode_t;

    // program entry points
    localparam logic [3:0] PC_HELLO       = 4'd0;
    localparam logic [3:0] PC_XCLIENT     = 4'd1;
    localparam logic [3:0] PC_MAIL        = 4'd2;
    localparam logic [3:0] PC_MAIL_PIPE   = 4'd3;
    localparam logic [3:0] PC_RCPT        = 4'd6;
    localparam logic [3:0] PC_DATA        = 4'd7;
    localparam logic [3:0] PC_BODY        = 4'd8;
    localparam logic [3:0] PC_STATUS      = 4'd9;
    localparam logic [3:0] PC_STATUS_QUIT = 4'd10;
    localparam logic [3:0] PC_STATUS_ALL  = 4'd12;
    localparam logic [3:0] PC_CLOSE       = 4'd14;
    localparam logic [3:0] PC_FAULT       = 4'd15;

    function automatic ucode_t uw(action_t act, logic hello, logic loop, logic use_idx,
                                  logic use_code, logic use_kind, logic succ,
                                  logic last_step);
        ucode_t w;
        w.act       = act;
        w.hello     = hello;
        w.loop      = loop;
        w.use_idx   = use_idx;
        w.use_code  = use_code;
        w.use_kind  = use_kind;
        w.succ      = succ;
        w.last_step = last_step;
        return w;
    endfunction

    // control store
    function automatic ucode_t ucode_rom(logic [3:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = uw(A_EHLO,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd1:    w = uw(A_XCLIENT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd2:    w = uw(A_MAIL,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd3:    w = uw(A_MAIL,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd4:    w = uw(A_RCPT,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd5:    w = uw(A_DATA,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd6:    w = uw(A_RCPT,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd7:    w = uw(A_DATA,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd8:    w = uw(A_BODY,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            4'd9:    w = uw(A_STATUS,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
            4'd10:   w = uw(A_STATUS,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            4'd11:   w = uw(A_QUIT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            4'd12:   w = uw(A_STATUS,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
            4'd13:   w = uw(A_QUIT,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            4'd14:   w = uw(A_CLOSE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            default: w = uw(A_FAULT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/smtp_client_command_sequencer_top.sv -----
// smtp_client_command_sequencer_top: client command sequencer for smtp and lmtp delivery
// depends on smtp_seq_pkg (states, action codes, control store)
`timescale 1ns / 1ps

// usage
//   s_* channel: one item per session event. tuser carries the op (connect, reply line,
//   timeout); tdata carries the summarized reply line.
//   m_* channel: command tokens, recipient status records, faults and the success mark.
//   tuser is the action code, tlast marks the final result of one input item.
//   cfg_* channel: register writes (0 lmtp_mode, 1 recipient_count), always ready; write
//   only while the block is idle.
// timing
//   an accepted item is decoded in its accept cycle; protocol state updates at once.
//   when it causes results, a microprogram starts and emits one result per cycle, unless
//   m_tready stalls it, into the output register; the start is registered in the step
//   counter first. a recipient loop that ends (a pipelined MAIL burst or the smtp status
//   sweep) adds an idle step; a burst holds up to 34 results.
//   s_tready is low while a program runs; it rises with the final result, so the next
//   item can be taken while that result still waits in the output register.
// reset
//   protocol state to START, learned flags and recipient index cleared, registers
//   cleared, no program running and no result pending.
// stalls
//   a low m_tready with a result pending freezes the step counter; nothing is dropped or repeated.

module smtp_client_command_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reply_code[9:0], code_valid, is_continuation,
                                   // has_xclient, has_pipelining, 2 bits zero
    input  logic [1:0]  s_tuser,   // op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // rcpt_index[4:0], status_code[9:0], fault_kind[3:0],
                                   // session_success, 4 bits zero
    output logic [3:0]  m_tuser,   // action
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    // input fields
    logic [9:0] in_code;
    logic       in_valid_code;
    logic       in_cont;
    logic       in_xc;
    logic       in_pl;
    logic       in_accept;

    assign in_code       = s_tdata[9:0];
    assign in_valid_code = s_tdata[10];
    assign in_cont       = s_tdata[11];
    assign in_xc         = s_tdata[12];
    assign in_pl         = s_tdata[13];
    assign in_accept     = s_tvalid && s_tready;

    // configuration
    logic       lmtp_reg;
    logic [5:0] rcpt_count_reg;
    logic [5:0] total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmtp_reg       <= 1'b0;
            rcpt_count_reg <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                smtp_seq_pkg::CFG_LMTP_MODE:  lmtp_reg       <= cfg_data[0];
                smtp_seq_pkg::CFG_RCPT_COUNT: rcpt_count_reg <= cfg_data;
                default:                      lmtp_reg       <= lmtp_reg;
            endcase
        end
    end

    // recipient count clamped to the list capacity
    assign total = (rcpt_count_reg > 6'(smtp_seq_pkg::RCPT_MAX))
                 ? 6'(smtp_seq_pkg::RCPT_MAX) : rcpt_count_reg;

    // protocol state
    smtp_seq_pkg::proto_state_t state_reg, state_next;
    logic       xc_seen_reg, xc_seen_next;
    logic       pl_seen_reg, pl_seen_next;
    logic [5:0] cur_reg, cur_next;

    // program start and its arguments
    logic       start_prog;
    logic [3:0] entry_pc;
    logic [4:0] arg_idx_reg, arg_idx_next;
    logic [9:0] arg_code_reg, arg_code_next;
    logic [3:0] arg_kind_reg, arg_kind_next;

    // decode: everything the model does to state happens at accept,
    // the emission sequence is left to the control store
    logic        is_done;
    logic        has_expect;
    logic [9:0]  expect_code;
    logic        xc_now;
    logic        pl_now;
    logic [5:0]  cur_inc;

    always_comb
    begin
        state_next    = state_reg;
        xc_seen_next  = xc_seen_reg;
        pl_seen_next  = pl_seen_reg;
        cur_next      = cur_reg;
        start_prog    = 1'b0;
        entry_pc      = smtp_seq_pkg::PC_FAULT;
        arg_idx_next  = arg_idx_reg;
        arg_code_next = arg_code_reg;
        arg_kind_next = arg_kind_reg;

        is_done = (state_reg == smtp_seq_pkg::ST_AFTER_QUIT)
               || (state_reg == smtp_seq_pkg::ST_ERROR);
        cur_inc = cur_reg + 6'd1;

        case (state_reg)
            smtp_seq_pkg::ST_START, smtp_seq_pkg::ST_START_XCLIENT:
            begin
                has_expect  = 1'b1;
                expect_code = smtp_seq_pkg::CODE_GREETING;
            end
            smtp_seq_pkg::ST_HELLO, smtp_seq_pkg::ST_HELLO_XCLIENT,
            smtp_seq_pkg::ST_AFTER_MAIL, smtp_seq_pkg::ST_AFTER_RCPT:
            begin
                has_expect  = 1'b1;
                expect_code = smtp_seq_pkg::CODE_OK;
            end
            smtp_seq_pkg::ST_AFTER_DATA:
            begin
                has_expect  = 1'b1;
                expect_code = smtp_seq_pkg::CODE_DATA_GO;
            end
            default:
            begin
                has_expect  = 1'b0;
                expect_code = 10'd0;
            end
        endcase

        // capability flags are learned only while in HELLO
        xc_now = xc_seen_reg || ((state_reg == smtp_seq_pkg::ST_HELLO) && in_xc);
        pl_now = pl_seen_reg || ((state_reg == smtp_seq_pkg::ST_HELLO) && in_pl);

        if (in_accept)
        begin
            case (smtp_seq_pkg::op_t'(s_tuser))
                smtp_seq_pkg::OP_CONNECT:
                begin
                    state_next   = smtp_seq_pkg::ST_START;
                    xc_seen_next = 1'b0;
                    pl_seen_next = 1'b0;
                    cur_next     = 6'd0;
                end
                smtp_seq_pkg::OP_TIMEOUT:
                begin
                    if (!is_done)
                    begin
                        start_prog    = 1'b1;
                        entry_pc      = smtp_seq_pkg::PC_FAULT;
                        arg_kind_next = smtp_seq_pkg::FK_TIMEOUT;
                        state_next    = smtp_seq_pkg::ST_ERROR;
                    end
                end
                smtp_seq_pkg::OP_REPLY:
                begin
                    if (!in_valid_code)
                    begin
                        if (!is_done)
                        begin
                            start_prog    = 1'b1;
                            entry_pc      = smtp_seq_pkg::PC_FAULT;
                            arg_kind_next = smtp_seq_pkg::FK_BAD_CODE;
                            state_next    = smtp_seq_pkg::ST_ERROR;
                        end
                    end
                    else if (has_expect && (in_code != expect_code))
                    begin
                        start_prog    = 1'b1;
                        entry_pc      = smtp_seq_pkg::PC_FAULT;
                        arg_kind_next = smtp_seq_pkg::FK_STATE_BASE + state_reg;
                        state_next    = smtp_seq_pkg::ST_ERROR;
                    end
                    else
                    begin
                        xc_seen_next = xc_now;
                        pl_seen_next = pl_now;
                        if (!in_cont)
                        begin
                            case (state_reg)
                                smtp_seq_pkg::ST_START:
                                begin
                                    start_prog = 1'b1;
                                    entry_pc   = smtp_seq_pkg::PC_HELLO;
                                    state_next = smtp_seq_pkg::ST_HELLO;
                                end
                                smtp_seq_pkg::ST_START_XCLIENT:
                                begin
                                    start_prog = 1'b1;
                                    entry_pc   = smtp_seq_pkg::PC_HELLO;
                                    state_next = smtp_seq_pkg::ST_HELLO_XCLIENT;
                                end
                                smtp_seq_pkg::ST_HELLO, smtp_seq_pkg::ST_HELLO_XCLIENT:
                                begin
                                    start_prog = 1'b1;
                                    if ((state_reg == smtp_seq_pkg::ST_HELLO) && xc_now)
                                    begin
                                        entry_pc   = smtp_seq_pkg::PC_XCLIENT;
                                        state_next = smtp_seq_pkg::ST_START_XCLIENT;
                                    end
                                    else
                                    begin
                                        entry_pc   = pl_now ? smtp_seq_pkg::PC_MAIL_PIPE
                                                            : smtp_seq_pkg::PC_MAIL;
                                        state_next = smtp_seq_pkg::ST_AFTER_MAIL;
                                    end
                                end
                                smtp_seq_pkg::ST_AFTER_MAIL:
                                begin
                                    cur_next = 6'd0;
                                    if (total == 6'd0)
                                    begin
                                        start_prog    = 1'b1;
                                        entry_pc      = smtp_seq_pkg::PC_FAULT;
                                        arg_kind_next = smtp_seq_pkg::FK_NO_RCPT;
                                        state_next    = smtp_seq_pkg::ST_ERROR;
                                    end
                                    else
                                    begin
                                        start_prog   = !pl_now;
                                        entry_pc     = smtp_seq_pkg::PC_RCPT;
                                        arg_idx_next = 5'd0;
                                        state_next   = smtp_seq_pkg::ST_AFTER_RCPT;
                                    end
                                end
                                smtp_seq_pkg::ST_AFTER_RCPT:
                                begin
                                    cur_next     = cur_inc;
                                    start_prog   = !pl_now;
                                    arg_idx_next = cur_inc[4:0];
                                    if (cur_inc >= total)
                                    begin
                                        entry_pc   = smtp_seq_pkg::PC_DATA;
                                        state_next = smtp_seq_pkg::ST_AFTER_DATA;
                                    end
                                    else
                                    begin
                                        entry_pc = smtp_seq_pkg::PC_RCPT;
                                    end
                                end
                                smtp_seq_pkg::ST_AFTER_DATA:
                                begin
                                    if (lmtp_reg)
                                    begin
                                        cur_next = 6'd0;
                                    end
                                    start_prog = 1'b1;
                                    entry_pc   = smtp_seq_pkg::PC_BODY;
                                    state_next = smtp_seq_pkg::ST_AFTER_DOT;
                                end
                                smtp_seq_pkg::ST_AFTER_DOT:
                                begin
                                    start_prog    = 1'b1;
                                    arg_code_next = in_code;
                                    if (lmtp_reg)
                                    begin
                                        // one final reply per recipient
                                        arg_idx_next = cur_reg[4:0];
                                        cur_next     = cur_inc;
                                        if (cur_inc >= total)
                                        begin
                                            entry_pc   = smtp_seq_pkg::PC_STATUS_QUIT;
                                            state_next = smtp_seq_pkg::ST_AFTER_QUIT;
                                        end
                                        else
                                        begin
                                            entry_pc = smtp_seq_pkg::PC_STATUS;
                                        end
                                    end
                                    else
                                    begin
                                        // one reply covers the whole list
                                        entry_pc   = smtp_seq_pkg::PC_STATUS_ALL;
                                        cur_next   = total;
                                        state_next = smtp_seq_pkg::ST_AFTER_QUIT;
                                    end
                                end
                                smtp_seq_pkg::ST_AFTER_QUIT:
                                begin
                                    start_prog = 1'b1;
                                    entry_pc   = smtp_seq_pkg::PC_CLOSE;
                                end
                                default:
                                begin
                                    start_prog = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    start_prog = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= smtp_seq_pkg::ST_START;
            xc_seen_reg <= 1'b0;
            pl_seen_reg <= 1'b0;
            cur_reg     <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            xc_seen_reg <= xc_seen_next;
            pl_seen_reg <= pl_seen_next;
            cur_reg     <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_idx_reg  <= arg_idx_next;
        arg_code_reg <= arg_code_next;
        arg_kind_reg <= arg_kind_next;
    end

    // sequencer: step counter, loop counter and the output register
    logic                 busy_reg, busy_next;
    logic [3:0]           pc_reg, pc_next;
    logic [5:0]           cnt_reg, cnt_next;
    smtp_seq_pkg::ucode_t word;
    logic                 out_free;
    logic                 loop_more;
    logic                 emit;

    logic                  m_valid_reg, m_valid_next;
    smtp_seq_pkg::action_t m_act_reg, m_act_next;
    logic [4:0]            m_idx_reg, m_idx_next;
    logic [9:0]            m_code_reg, m_code_next;
    logic [3:0]            m_kind_reg, m_kind_next;
    logic                  m_succ_reg, m_succ_next;
    logic                  m_last_reg, m_last_next;

    assign word      = smtp_seq_pkg::ucode_rom(pc_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign loop_more = cnt_reg < total;
    assign emit      = busy_reg && out_free && (!word.loop || loop_more);
    assign s_tready  = !busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_act_next   = m_act_reg;
        m_idx_next   = m_idx_reg;
        m_code_next  = m_code_reg;
        m_kind_next  = m_kind_reg;
        m_succ_next  = m_succ_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (busy_reg && out_free)
        begin
            if (word.loop)
            begin
                // one recipient a step; a spent loop costs one idle step
                if (loop_more)
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
                else
                begin
                    pc_next = pc_reg + 4'd1;
                end
            end
            else if (word.last_step)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end
        end

        if (emit)
        begin
            m_valid_next = 1'b1;
            if (word.hello)
            begin
                m_act_next = lmtp_reg ? smtp_seq_pkg::A_LHLO : smtp_seq_pkg::A_EHLO;
            end
            else
            begin
                m_act_next = word.act;
            end
            if (word.loop)
            begin
                m_idx_next = cnt_reg[4:0];
            end
            else
            begin
                m_idx_next = word.use_idx ? arg_idx_reg : 5'd0;
            end
            m_code_next = word.use_code ? arg_code_reg : 10'd0;
            m_kind_next = word.use_kind ? arg_kind_reg : smtp_seq_pkg::FK_NONE;
            m_succ_next = word.succ;
            m_last_next = word.last_step;
        end

        if (start_prog)
        begin
            busy_next = 1'b1;
            pc_next   = entry_pc;
            cnt_next  = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pc_reg      <= 4'd0;
            cnt_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_act_reg  <= m_act_next;
        m_idx_reg  <= m_idx_next;
        m_code_reg <= m_code_next;
        m_kind_reg <= m_kind_next;
        m_succ_reg <= m_succ_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_act_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_succ_reg, m_kind_reg, m_code_reg, m_idx_reg};

`ifndef NO_ASSERTIONS
    // the final step of a program frees the sequencer
    a_last_ends_prog: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && word.last_step) |=> !busy_reg)
        else $error("sequencer still busy after final result");

    // loop counter never runs past the list capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'(smtp_seq_pkg::RCPT_MAX))
        else $error("recipient loop counter out of range");

    // success is only marked on the closing quit of a burst
    a_succ_on_quit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_succ_reg) |-> (m_act_reg == smtp_seq_pkg::A_QUIT && m_last_reg))
        else $error("success mark outside final quit");

    // an item that starts a program shows its first result or busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_prog |=> (busy_reg || m_valid_reg))
        else $error("program start lost");
`endif

endmodule

// ----- tb/sv/smtp_client_command_sequencer_top_tb.sv -----
// smtp_client_command_sequencer_top_tb: self-checking bench for the smtp/lmtp command sequencer
// drives session items with random gaps, predicts command tokens and checks every result item
// depends on smtp_seq_pkg and smtp_client_command_sequencer_top
`timescale 1ns / 1ps

module smtp_client_command_sequencer_top_tb;

    import smtp_seq_pkg::*;

    // generous bound on the whole run, far above the slowest legal schedule
    localparam int CYCLE_LIMIT = 1000000;
    // quiet cycles before a register write or the end, covers the longest burst
    localparam int SETTLE_CYCLES = 40;
    // stimulus stops after the phase in which this many items other than the ignored op have been queued
    localparam int ITEM_TARGET = 370;

    // one session item as it enters the block
    typedef struct packed {
        op_t        op;
        logic [9:0] reply_code;
        logic       code_valid;
        logic       is_continuation;
        logic       has_xclient;
        logic       has_pipelining;
    } session_event_t;

    // one result item as it leaves the block
    typedef struct packed {
        action_t    action;
        logic [4:0] rcpt_index;
        logic [9:0] status_code;
        logic [3:0] fault_kind;
        logic       session_success;
        logic       last;
    } command_token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_LMTP_MODE;
    logic [5:0]  cfg_data = '0;

    // stimulus and expectation stores
    session_event_t session_events[$];
    command_token_t awaited_tokens[$];
    session_event_t held_event;
    int             events_queued = 0;
    int             events_taken = 0;
    int             events_meaningful = 0;
    int             failures = 0;
    int             cycle_count = 0;
    int             gap_left = 0;
    int             stall_left = 0;
    logic           no_idle = 1'b0;

    // predictor copy of the registers and the protocol state
    logic           lmtp_on = 1'b0;
    logic [5:0]     rcpt_limit = '0;
    proto_state_t   sess_state = ST_START;
    logic           xclient_learned = 1'b0;
    logic           pipelining_learned = 1'b0;
    logic [5:0]     rcpt_cursor = '0;
    int             burst_len = 0;

    // session generator bookkeeping for the at most one broken item per session
    int             step_no = 0;
    int             break_at = -1;
    logic           broken = 1'b0;

    smtp_client_command_sequencer_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic void emit_token(action_t act, logic [4:0] idx, logic [9:0] code,
                                       logic [3:0] kind, logic succ);
        command_token_t t;
        t.action          = act;
        t.rcpt_index      = idx;
        t.status_code     = code;
        t.fault_kind      = kind;
        t.session_success = succ;
        t.last            = 1'b0;
        awaited_tokens.insert(awaited_tokens.size(), t);
        burst_len++;
    endfunction

    // every fault ends the session until the next connect
    function automatic void raise_fault(logic [3:0] kind);
        emit_token(A_FAULT, '0, '0, kind, 1'b0);
        sess_state = ST_ERROR;
    endfunction

    // apply one accepted item to the session and queue the tokens it causes
    task automatic advance_session(input session_event_t ev);
        logic [5:0]     total;
        action_t        hello_tok;
        logic [9:0]     want;
        logic           closed;
        int             i;
        total     = (rcpt_limit > 6'(RCPT_MAX)) ? 6'(RCPT_MAX) : rcpt_limit;
        hello_tok = lmtp_on ? A_LHLO : A_EHLO;
        closed    = (sess_state == ST_AFTER_QUIT || sess_state == ST_ERROR);
        burst_len = 0;
        case (ev.op)
            OP_CONNECT:
            begin
                sess_state         = ST_START;
                xclient_learned    = 1'b0;
                pipelining_learned = 1'b0;
                rcpt_cursor        = '0;
            end
            OP_TIMEOUT:
            begin
                if (!closed)
                    raise_fault(FK_TIMEOUT);
            end
            OP_REPLY:
            begin
                case (sess_state)
                    ST_START, ST_START_XCLIENT: want = CODE_GREETING;
                    ST_HELLO, ST_HELLO_XCLIENT,
                    ST_AFTER_MAIL, ST_AFTER_RCPT: want = CODE_OK;
                    ST_AFTER_DATA: want = CODE_DATA_GO;
                    default: want = '0;
                endcase
                if (!ev.code_valid)
                begin
                    // a line without digits is silent once the session is over
                    if (!closed)
                        raise_fault(FK_BAD_CODE);
                end
                else if (want != '0 && ev.reply_code != want)
                    raise_fault(FK_STATE_BASE + 4'(sess_state));
                else
                begin
                    // capabilities count from every hello line, continuation or not
                    if (sess_state == ST_HELLO)
                    begin
                        if (ev.has_xclient)
                            xclient_learned = 1'b1;
                        if (ev.has_pipelining)
                            pipelining_learned = 1'b1;
                    end
                    if (!ev.is_continuation)
                    begin
                        case (sess_state)
                            ST_START:
                            begin
                                emit_token(hello_tok, '0, '0, FK_NONE, 1'b0);
                                sess_state = ST_HELLO;
                            end
                            ST_START_XCLIENT:
                            begin
                                emit_token(hello_tok, '0, '0, FK_NONE, 1'b0);
                                sess_state = ST_HELLO_XCLIENT;
                            end
                            ST_HELLO, ST_HELLO_XCLIENT:
                            begin
                                if (sess_state == ST_HELLO && xclient_learned)
                                begin
                                    emit_token(A_XCLIENT, '0, '0, FK_NONE, 1'b0);
                                    sess_state = ST_START_XCLIENT;
                                end
                                else
                                begin
                                    // with pipelining the envelope goes out in one burst
                                    emit_token(A_MAIL, '0, '0, FK_NONE, 1'b0);
                                    if (pipelining_learned)
                                    begin
                                        for (i = 0; i < total; i++)
                                            emit_token(A_RCPT, 5'(i), '0, FK_NONE, 1'b0);
                                        emit_token(A_DATA, '0, '0, FK_NONE, 1'b0);
                                    end
                                    sess_state = ST_AFTER_MAIL;
                                end
                            end
                            ST_AFTER_MAIL:
                            begin
                                rcpt_cursor = '0;
                                if (total == '0)
                                    raise_fault(FK_NO_RCPT);
                                else
                                begin
                                    if (!pipelining_learned)
                                        emit_token(A_RCPT, '0, '0, FK_NONE, 1'b0);
                                    sess_state = ST_AFTER_RCPT;
                                end
                            end
                            ST_AFTER_RCPT:
                            begin
                                // a cursor already past a lowered count also ends the list
                                rcpt_cursor = rcpt_cursor + 6'd1;
                                if (rcpt_cursor >= total)
                                begin
                                    if (!pipelining_learned)
                                        emit_token(A_DATA, '0, '0, FK_NONE, 1'b0);
                                    sess_state = ST_AFTER_DATA;
                                end
                                else if (!pipelining_learned)
                                    emit_token(A_RCPT, rcpt_cursor[4:0], '0, FK_NONE, 1'b0);
                            end
                            ST_AFTER_DATA:
                            begin
                                if (lmtp_on)
                                    rcpt_cursor = '0;
                                emit_token(A_BODY, '0, '0, FK_NONE, 1'b0);
                                sess_state = ST_AFTER_DOT;
                            end
                            ST_AFTER_DOT:
                            begin
                                if (lmtp_on)
                                begin
                                    // one final reply per recipient
                                    emit_token(A_STATUS, rcpt_cursor[4:0], ev.reply_code,
                                               FK_NONE, 1'b0);
                                    rcpt_cursor = rcpt_cursor + 6'd1;
                                    if (rcpt_cursor >= total)
                                    begin
                                        emit_token(A_QUIT, '0, '0, FK_NONE, 1'b1);
                                        sess_state = ST_AFTER_QUIT;
                                    end
                                end
                                else
                                begin
                                    // one reply stands for every recipient
                                    for (i = 0; i < total; i++)
                                        emit_token(A_STATUS, 5'(i), ev.reply_code,
                                                   FK_NONE, 1'b0);
                                    rcpt_cursor = total;
                                    emit_token(A_QUIT, '0, '0, FK_NONE, 1'b1);
                                    sess_state = ST_AFTER_QUIT;
                                end
                            end
                            ST_AFTER_QUIT:
                                emit_token(A_CLOSE, '0, '0, FK_NONE, 1'b0);
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        // tlast goes on the final token of this item
        if (burst_len > 0)
            awaited_tokens[awaited_tokens.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- driver

    // holds each item until taken, then waits a random gap before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_NONE;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_session(held_event);
                events_taken++;
                gap_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || session_events.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    held_event = session_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= held_event.op;
                    // reply_code, code_valid, is_continuation, has_xclient, has_pipelining
                    s_tdata  <= {2'b00, held_event.has_pipelining, held_event.has_xclient,
                                 held_event.is_continuation, held_event.code_valid,
                                 held_event.reply_code};
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // takes result items, stalling a random number of cycles after each one
    always @(posedge clk or negedge rst_n)
    begin : token_monitor
        command_token_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_tokens.size() == 0)
                begin
                    $error("unexpected result item: action %0d, tdata %h", m_tuser, m_tdata);
                    failures++;
                end
                else
                begin
                    want = awaited_tokens.pop_front();
                    check_field("action", want.action, m_tuser);
                    check_field("rcpt_index", want.rcpt_index, m_tdata[4:0]);
                    check_field("status_code", want.status_code, m_tdata[14:5]);
                    check_field("fault_kind", want.fault_kind, m_tdata[18:15]);
                    check_field("session_success", want.session_success, m_tdata[19]);
                    check_field("last", want.last, m_tlast);
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic session_event_t line_event(op_t op, logic [9:0] code, logic valid,
                                                  logic cont, logic xc, logic pl);
        session_event_t ev;
        ev.op              = op;
        ev.reply_code      = code;
        ev.code_valid      = valid;
        ev.is_continuation = cont;
        ev.has_xclient     = xc;
        ev.has_pipelining  = pl;
        return ev;
    endfunction

    function automatic session_event_t reply_line(logic [9:0] code, logic cont, logic xc,
                                                  logic pl);
        return line_event(OP_REPLY, code, 1'b1, cont, xc, pl);
    endfunction

    // anything at all, including the ignored op
    function automatic session_event_t random_event();
        return line_event(op_t'($urandom_range(0, 3)), 10'($urandom_range(0, 999)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic post_event(input session_event_t ev);
        session_events.insert(session_events.size(), ev);
        events_queued++;
        if (ev.op != OP_NONE)
            events_meaningful++;
    endtask

    // queue a step of a well-formed session, or break the session at the chosen step
    task automatic offer(input session_event_t ev);
        session_event_t bad;
        if (!broken)
        begin
            if (step_no == break_at)
            begin
                bad = ev;
                case ($urandom_range(0, 3))
                    0: bad.op = OP_TIMEOUT;
                    1: bad.code_valid = 1'b0;
                    2: bad.reply_code = 10'($urandom_range(0, 999));
                    default: bad.op = OP_CONNECT;
                endcase
                post_event(bad);
                // random leftovers follow the broken item
                repeat ($urandom_range(0, 2))
                    post_event(random_event());
                broken = 1'b1;
            end
            else
                post_event(ev);
            step_no++;
        end
    endtask

    // one delivery from connect to quit with random content, broken now and then
    task automatic queue_session();
        int   total;
        logic xc_any;
        logic xc;
        total    = (rcpt_limit > 6'(RCPT_MAX)) ? RCPT_MAX : rcpt_limit;
        step_no  = 0;
        broken   = 1'b0;
        break_at = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 8 + total) : -1;
        xc_any   = 1'b0;
        offer(line_event(OP_CONNECT, 10'($urandom_range(0, 999)), coin(), coin(), coin(),
                         coin()));
        repeat ($urandom_range(0, 1))
            offer(reply_line(CODE_GREETING, 1'b1, coin(), coin()));
        offer(reply_line(CODE_GREETING, 1'b0, coin(), coin()));
        // capability lines, the last one final
        repeat ($urandom_range(0, 3))
        begin
            xc = ($urandom_range(0, 5) == 0);
            xc_any |= xc;
            offer(reply_line(CODE_OK, 1'b1, xc, coin()));
        end
        xc = ($urandom_range(0, 5) == 0);
        xc_any |= xc;
        offer(reply_line(CODE_OK, 1'b0, xc, coin()));
        // xclient round trip: new greeting, second hello
        if (xc_any)
        begin
            offer(reply_line(CODE_GREETING, 1'b0, coin(), coin()));
            offer(reply_line(CODE_OK, 1'b0, coin(), coin()));
        end
        if (coin())
            offer(reply_line(CODE_OK, 1'b1, coin(), coin()));
        offer(reply_line(CODE_OK, 1'b0, coin(), coin()));
        if (total > 0)
        begin
            repeat (total)
                offer(reply_line(CODE_OK, 1'b0, coin(), coin()));
            offer(reply_line(CODE_DATA_GO, 1'b0, coin(), coin()));
            repeat (lmtp_on ? total : 1)
                offer(reply_line(10'($urandom_range(0, 999)), 1'b0, coin(), coin()));
            // after quit: close on a reply, silence on the rest
            repeat ($urandom_range(0, 2))
                offer(random_event());
        end
    endtask

    task automatic write_register(input logic idx, input logic [5:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LMTP_MODE)
            lmtp_on = value[0];
        else
            rcpt_limit = value;
    endtask

    // sender holds off until every queued item is taken and every token has come back
    task automatic drain();
        while (events_taken != events_queued || awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         phase_no;
        logic [5:0] count;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // pipelined smtp with xclient, two recipients, extreme codes
        write_register(CFG_LMTP_MODE, 6'd0);
        write_register(CFG_RCPT_COUNT, 6'd2);
        post_event(line_event(OP_NONE, 10'd999, 1'b1, 1'b1, 1'b1, 1'b1));
        post_event(line_event(OP_CONNECT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_GREETING, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_OK, 1'b1, 1'b1, 1'b0));
        post_event(reply_line(CODE_OK, 1'b1, 1'b0, 1'b1));
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_GREETING, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        repeat (3)
            post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_DATA_GO, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(10'd999, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(10'd0, 1'b0, 1'b0, 1'b0));
        post_event(line_event(OP_TIMEOUT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        drain();

        // empty recipient list faults on the reply to mail
        write_register(CFG_RCPT_COUNT, 6'd0);
        post_event(line_event(OP_CONNECT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_GREETING, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        drain();

        // lmtp, count lowered below the recipient cursor mid-session
        write_register(CFG_LMTP_MODE, 6'd1);
        write_register(CFG_RCPT_COUNT, 6'd5);
        post_event(line_event(OP_CONNECT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_GREETING, 1'b0, 1'b0, 1'b0));
        repeat (4)
            post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        drain();
        write_register(CFG_RCPT_COUNT, 6'd1);
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_DATA_GO, 1'b0, 1'b0, 1'b0));
        post_event(reply_line(CODE_OK, 1'b0, 1'b0, 1'b0));
        drain();

        // random sessions, a new setting per phase, every fourth phase without idling
        phase_no = 0;
        while (events_meaningful < ITEM_TARGET)
        begin
            no_idle = (phase_no % 4 == 3);
            case (phase_no)
                1: count = 6'd32;
                3: count = 6'd63;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: count = 6'd0;
                        9: count = 6'($urandom_range(5, 12));
                        default: count = 6'($urandom_range(1, 4));
                    endcase
                end
            endcase
            write_register(CFG_LMTP_MODE, 6'($urandom_range(0, 1)));
            write_register(CFG_RCPT_COUNT, count);
            repeat ($urandom_range(2, 3))
                queue_session();
            drain();
            phase_no++;
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
